// ===== rtl/atwa_pkg.sv =====
// Shared types, command codes and defaults for the alternating triggered
// window averager. No dependencies; every other RTL file uses this package.
`default_nettype none

package atwa_pkg;

   // Default geometry and register reset
   localparam int PRE_SAMPLES_DEF  = 256;
   localparam int POST_SAMPLES_DEF = 768;
   localparam int WINDOW_DEPTH_DEF = 1024;

   localparam int ALPHA_W = 17;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd9830;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

   // Command codes on the request channel
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] sample_value;
      logic               event_mark;
      logic               read_select;
      logic [9:0]         read_index;
   } atwa_req_type;

   typedef struct packed {
      logic signed [31:0] average_value;
      logic               average_valid;
   } atwa_rsp_type;

   // Decoded operation handed from front to back
   typedef enum logic [1:0] {
      OP_PUSH,
      OP_READ,
      OP_CLEAR
   } atwa_op_type;

   typedef struct packed {
      atwa_op_type        op;
      logic signed [15:0] sample_value;
      logic               event_mark;
      logic               read_select;
      logic [9:0]         read_index;
   } atwa_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ_OUT,
      ST_SWEEP,
      ST_DRAIN
   } atwa_state_type;

endpackage

`default_nettype wire

// ===== rtl/atwa_front.sv =====
// Front end: accepts request beats, decodes the command and queues the
// operation in a two-entry FIFO for the back end. Uses atwa_pkg.
`default_nettype none

module atwa_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  atwa_pkg::atwa_req_type  req_data,
   output logic                    q_valid,
   output atwa_pkg::atwa_item_type q_item,
   input  wire                     q_pop
);

   atwa_pkg::atwa_item_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   atwa_pkg::atwa_item_type decoded;
   logic                    keep;
   logic                    accept;
   logic                    push;
   logic                    pop;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   // Classify the command; unused codes are taken and dropped
   always_comb begin
      decoded.sample_value = req_data.sample_value;
      decoded.event_mark   = req_data.event_mark;
      decoded.read_select  = req_data.read_select;
      decoded.read_index   = req_data.read_index;
      decoded.op           = atwa_pkg::OP_PUSH;
      keep                 = 1'b1;
      case (req_data.command)
         atwa_pkg::CMD_PUSH:  decoded.op = atwa_pkg::OP_PUSH;
         atwa_pkg::CMD_READ:  decoded.op = atwa_pkg::OP_READ;
         atwa_pkg::CMD_CLEAR: decoded.op = atwa_pkg::OP_CLEAR;
         default:             keep = 1'b0;
      endcase
   end

   assign push = accept && keep;
   assign pop  = q_pop && q_valid;

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atwa_back.sv =====
// Back end: sample ring, tic/toc average memory, window sweep pipeline and
// the result register. Executes queued operations in order. Uses atwa_pkg.
`default_nettype none

module atwa_back #(
   parameter int PRE_SAMPLES  = atwa_pkg::PRE_SAMPLES_DEF,
   parameter int POST_SAMPLES = atwa_pkg::POST_SAMPLES_DEF,
   parameter int WINDOW_DEPTH = atwa_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire [atwa_pkg::ALPHA_W-1:0]      alpha,
   input  wire                              q_valid,
   input  atwa_pkg::atwa_item_type          q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output atwa_pkg::atwa_rsp_type           rsp_data
);

   localparam int WIN_LEN = PRE_SAMPLES + POST_SAMPLES;
   localparam int NBINS   = (WIN_LEN < WINDOW_DEPTH) ? WIN_LEN : WINDOW_DEPTH;
   localparam int RAW     = $clog2(WINDOW_DEPTH);
   localparam int BAW     = $clog2(NBINS);
   localparam int CW      = $clog2(WIN_LEN + 1);
   localparam int IW      = (BAW + 1 > 10) ? BAW + 1 : 10;
   localparam int BACK_T  = (POST_SAMPLES - 1) % WINDOW_DEPTH;
   localparam int BACK_W  = (POST_SAMPLES - 1 + PRE_SAMPLES) % WINDOW_DEPTH;
   localparam bit MARK_BYPASS = (BACK_T == 0);

   // Storage
   logic [16:0] ring_mem [WINDOW_DEPTH];
   logic [31:0] avg_mem  [2**(BAW+1)];

   // Control state
   atwa_pkg::atwa_state_type state_ff, state_in;
   logic [RAW-1:0] wp_ff;
   logic [CW-1:0]  count_ff;
   logic           tic_filled_ff;
   logic           toc_filled_ff;
   logic           next_toc_ff;
   logic           rsp_valid_ff;
   logic           p1_ff, p2_ff, p3_ff;

   // Per-operation holding registers
   logic           mark_hold_ff;
   logic [RAW-1:0] start_ff;
   logic [RAW-1:0] sweep_addr_ff;
   logic [BAW-1:0] bin_ff;
   logic           kind_ff;
   logic           copy_ff;
   logic           rd_ok_ff;
   logic           rd_filled_ff;
   atwa_pkg::atwa_rsp_type rsp_data_ff;

   // Read data and pipeline registers
   logic [16:0]        ring_rd_ff;
   logic [31:0]        avg_rd_ff;
   logic [BAW-1:0]     bin_p1_ff, bin_p2_ff, bin_p3_ff;
   logic signed [32:0] diff_ff;
   logic signed [31:0] old_p2_ff, old_p3_ff;
   logic signed [15:0] samp_p2_ff, samp_p3_ff;
   logic signed [50:0] prod_ff;

   // FSM outputs
   logic           ring_we, ring_re, avg_re, avg_we;
   logic           do_clear, sweep_start, sweep_done, rsp_load;
   logic [RAW-1:0] ring_raddr;
   logic [BAW:0]   avg_raddr;

   // Ring address arithmetic (constant offsets, modulo the depth)
   logic [RAW-1:0] trig_addr;
   logic [RAW-1:0] start_addr;
   logic [RAW-1:0] wp_next;
   logic [IW-1:0]  idx_ext;
   logic           idx_in_range;
   logic           sel_filled;
   logic           mark_seen;
   logic           hit;
   logic           last_bin;

   assign trig_addr  = (wp_ff >= RAW'(BACK_T)) ? wp_ff - RAW'(BACK_T)
                                               : wp_ff + RAW'(WINDOW_DEPTH - BACK_T);
   assign start_addr = (wp_ff >= RAW'(BACK_W)) ? wp_ff - RAW'(BACK_W)
                                               : wp_ff + RAW'(WINDOW_DEPTH - BACK_W);
   assign wp_next    = (wp_ff == RAW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   assign idx_ext      = IW'(q_item.read_index);
   assign idx_in_range = (idx_ext < IW'(NBINS));
   assign sel_filled   = q_item.read_select ? toc_filled_ff : tic_filled_ff;

   assign mark_seen = MARK_BYPASS ? mark_hold_ff : ring_rd_ff[16];
   assign hit       = mark_seen && (count_ff == CW'(WIN_LEN));
   assign last_bin  = (bin_ff == BAW'(NBINS - 1));

   // Next state and control
   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      ring_we     = 1'b0;
      ring_re     = 1'b0;
      avg_re      = 1'b0;
      do_clear    = 1'b0;
      sweep_start = 1'b0;
      sweep_done  = 1'b0;
      rsp_load    = 1'b0;
      ring_raddr  = trig_addr;
      avg_raddr   = {q_item.read_select, idx_ext[BAW-1:0]};
      case (state_ff)
         atwa_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  atwa_pkg::OP_PUSH: begin
                     ring_we  = 1'b1;
                     ring_re  = 1'b1;
                     state_in = atwa_pkg::ST_CHECK;
                  end
                  atwa_pkg::OP_READ: begin
                     avg_re   = 1'b1;
                     state_in = atwa_pkg::ST_READ_OUT;
                  end
                  atwa_pkg::OP_CLEAR: do_clear = 1'b1;
                  default: ;
               endcase
            end
         end
         atwa_pkg::ST_CHECK: begin
            if (hit) begin
               sweep_start = 1'b1;
               state_in    = atwa_pkg::ST_SWEEP;
            end else begin
               state_in = atwa_pkg::ST_IDLE;
            end
         end
         atwa_pkg::ST_READ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = atwa_pkg::ST_IDLE;
            end
         end
         atwa_pkg::ST_SWEEP: begin
            ring_re    = 1'b1;
            avg_re     = 1'b1;
            ring_raddr = sweep_addr_ff;
            avg_raddr  = {kind_ff, bin_ff};
            if (last_bin) begin
               state_in = atwa_pkg::ST_DRAIN;
            end
         end
         atwa_pkg::ST_DRAIN: begin
            if (!p1_ff && !p2_ff && !p3_ff) begin
               sweep_done = 1'b1;
               state_in   = atwa_pkg::ST_IDLE;
            end
         end
         default: state_in = atwa_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= atwa_pkg::ST_IDLE;
         wp_ff         <= '0;
         count_ff      <= '0;
         tic_filled_ff <= 1'b0;
         toc_filled_ff <= 1'b0;
         next_toc_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         p3_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_ff    <= (state_ff == atwa_pkg::ST_SWEEP);
         p2_ff    <= p1_ff;
         p3_ff    <= p2_ff;
         if (do_clear) begin
            wp_ff         <= '0;
            count_ff      <= '0;
            tic_filled_ff <= 1'b0;
            toc_filled_ff <= 1'b0;
            next_toc_ff   <= 1'b0;
         end
         if (ring_we) begin
            wp_ff <= wp_next;
            if (count_ff != CW'(WIN_LEN)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         // Window finished: mark its average filled and swap turns
         if (sweep_done) begin
            next_toc_ff <= !next_toc_ff;
            if (kind_ff) begin
               toc_filled_ff <= 1'b1;
            end else begin
               tic_filled_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Operation holding registers and sweep counters
   always_ff @(posedge clock) begin
      if (ring_we) begin
         mark_hold_ff <= q_item.event_mark;
         start_ff     <= start_addr;
      end
      if (avg_re && state_ff == atwa_pkg::ST_IDLE) begin
         rd_ok_ff     <= sel_filled && idx_in_range;
         rd_filled_ff <= sel_filled;
      end
      if (sweep_start) begin
         sweep_addr_ff <= start_ff;
         bin_ff        <= '0;
         kind_ff       <= next_toc_ff;
         copy_ff       <= next_toc_ff ? !toc_filled_ff : !tic_filled_ff;
      end else if (state_ff == atwa_pkg::ST_SWEEP) begin
         sweep_addr_ff <= (sweep_addr_ff == RAW'(WINDOW_DEPTH - 1)) ? '0
                                                                    : sweep_addr_ff + 1'b1;
         bin_ff        <= bin_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_data_ff.average_value <= rd_ok_ff ? signed'(avg_rd_ff) : 32'sd0;
         rsp_data_ff.average_valid <= rd_filled_ff;
      end
   end

   // Sample ring: sample and trigger mark side by side
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= {q_item.event_mark, q_item.sample_value};
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[ring_raddr];
      end
   end

   // Average memory: tic in the lower half, toc in the upper
   logic signed [50:0] rounded;
   logic signed [34:0] step;
   logic signed [34:0] updated;
   logic [31:0]        avg_wdata;

   assign avg_we    = p3_ff;
   assign rounded   = prod_ff + 51'sd32768;
   assign step      = rounded[50:16];
   assign updated   = 35'(old_p3_ff) + step;
   assign avg_wdata = copy_ff ? {samp_p3_ff, 16'h0000} : updated[31:0];

   always_ff @(posedge clock) begin
      if (avg_we) begin
         avg_mem[{kind_ff, bin_p3_ff}] <= avg_wdata;
      end
      if (avg_re) begin
         avg_rd_ff <= avg_mem[avg_raddr];
      end
   end

   // Update pipeline: difference, weighted step, accumulate
   logic signed [31:0] win_p1;
   logic signed [31:0] old_p1;

   assign win_p1 = {ring_rd_ff[15:0], 16'h0000};
   assign old_p1 = avg_rd_ff;

   always_ff @(posedge clock) begin
      bin_p1_ff  <= bin_ff;
      bin_p2_ff  <= bin_p1_ff;
      bin_p3_ff  <= bin_p2_ff;
      diff_ff    <= 33'(win_p1) - 33'(old_p1);
      old_p2_ff  <= old_p1;
      samp_p2_ff <= ring_rd_ff[15:0];
      prod_ff    <= 51'($signed({1'b0, alpha}) * diff_ff);
      old_p3_ff  <= old_p2_ff;
      samp_p3_ff <= samp_p2_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/alternating_triggered_window_averager.sv =====
// Alternating triggered window averager.
//
// Request channel (req_valid / req_stall / req_data) carries push, read and
// clear commands; a beat is taken when req_valid is high and req_stall low.
// A pushed sample goes into a ring with its trigger mark. Once a marked
// sample has POST_SAMPLES-1 samples after it and full history, its window
// of PRE_SAMPLES+POST_SAMPLES bins is folded into the tic or toc average in
// turn: copied the first time, later updated as avg += alpha*(win-avg).
// A read returns one bin on the response channel (rsp_valid / rsp_stall /
// rsp_data); other commands give no response beat.
// A push that completes a window adds a sweep in which the one ring read
// port walks the window bin by bin; the engine takes no new operation
// until the sweep has drained.
// A two-entry queue sits in front of the engine.
// Reset clears pointers, history, filled flags and the tic/toc turn; alpha
// returns to 0.15. A stalled response holds in its register and the
// engine waits; requests keep queuing until the queue is full.
`default_nettype none

module alternating_triggered_window_averager #(
   parameter int PRE_SAMPLES  = atwa_pkg::PRE_SAMPLES_DEF,
   parameter int POST_SAMPLES = atwa_pkg::POST_SAMPLES_DEF,
   parameter int WINDOW_DEPTH = atwa_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  atwa_pkg::atwa_req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output atwa_pkg::atwa_rsp_type       rsp_data,
   input  wire                          csr_wr_en,
   input  wire [atwa_pkg::ALPHA_W-1:0]  csr_wr_data
);

   logic [atwa_pkg::ALPHA_W-1:0] alpha_ff;
   logic [atwa_pkg::ALPHA_W-1:0] alpha_eff;

   logic                    q_valid;
   logic                    q_pop;
   atwa_pkg::atwa_item_type q_item;

   // Averaging weight register; values above one act as one
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= atwa_pkg::ALPHA_RESET;
      end else if (csr_wr_en) begin
         alpha_ff <= csr_wr_data;
      end
   end

   assign alpha_eff = (alpha_ff > atwa_pkg::ALPHA_ONE) ? atwa_pkg::ALPHA_ONE : alpha_ff;

   atwa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   atwa_back #(
      .PRE_SAMPLES  (PRE_SAMPLES),
      .POST_SAMPLES (POST_SAMPLES),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .alpha     (alpha_eff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/atwa_bin_checker.sv =====
`timescale 1ns / 100ps
// Bin checker for the alternating triggered window averager: watches the
// request, response and register ports and predicts every read answer.
// Depends on atwa_pkg for the beat types, command codes and alpha constants.

module atwa_bin_checker #(
   parameter int PRE_SAMPLES  = atwa_pkg::PRE_SAMPLES_DEF,
   parameter int POST_SAMPLES = atwa_pkg::POST_SAMPLES_DEF,
   parameter int WINDOW_DEPTH = atwa_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_stall,
   input  atwa_pkg::atwa_req_type       req_data,
   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  atwa_pkg::atwa_rsp_type       rsp_data,
   input  wire                          csr_wr_en,
   input  wire [atwa_pkg::ALPHA_W-1:0]  csr_wr_data,
   output int                           mismatch_count,
   output int                           pending_reads
);

   localparam int WIN_LEN = PRE_SAMPLES + POST_SAMPLES;
   localparam int NBINS   = (WIN_LEN < WINDOW_DEPTH) ? WIN_LEN : WINDOW_DEPTH;

   // Predicted state; index 0 of the average arrays is tic, 1 is toc
   logic [atwa_pkg::ALPHA_W-1:0] alpha_weight;
   logic signed [15:0] sample_mem [WINDOW_DEPTH];
   logic               mark_mem [WINDOW_DEPTH];
   logic [31:0]        avg_mem [2][WINDOW_DEPTH];
   logic               avg_filled [2];
   logic               toc_turn;
   int                 hist_count;
   int                 write_ptr;

   // Read answers still owed by the block, oldest first
   atwa_pkg::atwa_rsp_type expected_bins [$];

   initial begin
      mismatch_count = 0;
      pending_reads  = 0;
   end

   function automatic int ring_back(int pos, int back);
      return (pos + WINDOW_DEPTH - (back % WINDOW_DEPTH)) % WINDOW_DEPTH;
   endfunction

   task automatic restart_session();
      foreach (sample_mem[i]) begin
         sample_mem[i] = '0;
         mark_mem[i]   = 1'b0;
         avg_mem[0][i] = '0;
         avg_mem[1][i] = '0;
      end
      avg_filled[0] = 1'b0;
      avg_filled[1] = 1'b0;
      toc_turn      = 1'b0;
      hist_count    = 0;
      write_ptr     = 0;
   endtask

   always @(posedge clock) begin : watch
      atwa_pkg::atwa_rsp_type exp_bin;
      int                 newest;
      int                 trig;
      int                 start;
      int                 addr;
      logic signed [31:0] old_v;
      longint             win_v;
      longint             step_v;
      longint             sum_v;
      longint             weight_v;
      logic               sel_toc;
      if (reset) begin
         restart_session();
         alpha_weight = atwa_pkg::ALPHA_RESET;
         expected_bins.delete();
      end else begin
         // Response beat against the oldest outstanding read
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with no read outstanding: value %0d valid %0b",
                           $realtime, rsp_data.average_value, rsp_data.average_valid);
            end else begin
               exp_bin = expected_bins.pop_front();
               if (exp_bin.average_value !== rsp_data.average_value ||
                   exp_bin.average_valid !== rsp_data.average_valid) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display({"%0t: bin mismatch: expected value %0d valid %0b,",
                               " got value %0d valid %0b"},
                              $realtime, exp_bin.average_value, exp_bin.average_valid,
                              rsp_data.average_value, rsp_data.average_valid);
               end
            end
         end

         if (csr_wr_en)
            alpha_weight = csr_wr_data;

         // Request beat: update the predicted state
         if (req_valid && !req_stall) begin
            case (req_data.command)
               atwa_pkg::CMD_PUSH: begin
                  newest = write_ptr;
                  sample_mem[newest] = req_data.sample_value;
                  mark_mem[newest]   = req_data.event_mark;
                  if (hist_count < WIN_LEN)
                     hist_count++;
                  trig = ring_back(newest, POST_SAMPLES - 1);
                  // marked sample now has its full window behind and ahead
                  if (mark_mem[trig] && hist_count >= WIN_LEN) begin
                     start    = ring_back(trig, PRE_SAMPLES);
                     weight_v = (alpha_weight > atwa_pkg::ALPHA_ONE)
                                ? longint'(atwa_pkg::ALPHA_ONE) : longint'(alpha_weight);
                     for (int i = 0; i < NBINS; i++) begin
                        addr  = (start + i) % WINDOW_DEPTH;
                        win_v = longint'(sample_mem[addr]) * 65536;
                        if (!avg_filled[toc_turn]) begin
                           avg_mem[toc_turn][i] = win_v[31:0];
                        end else begin
                           old_v  = avg_mem[toc_turn][i];
                           // rounded, floored Q16 step of the exact product
                           step_v = (weight_v * (win_v - longint'(old_v)) + 64'sd32768) >>> 16;
                           sum_v  = longint'(old_v) + step_v;
                           avg_mem[toc_turn][i] = sum_v[31:0];
                        end
                     end
                     avg_filled[toc_turn] = 1'b1;
                     toc_turn = ~toc_turn;
                  end
                  write_ptr = (newest + 1) % WINDOW_DEPTH;
               end
               atwa_pkg::CMD_READ: begin
                  sel_toc = req_data.read_select;
                  exp_bin.average_valid = avg_filled[sel_toc];
                  exp_bin.average_value = '0;
                  if (avg_filled[sel_toc] && req_data.read_index < NBINS)
                     exp_bin.average_value = avg_mem[sel_toc][req_data.read_index];
                  expected_bins.insert(expected_bins.size(), exp_bin);
               end
               atwa_pkg::CMD_CLEAR: restart_session();
               default: ;
            endcase
         end
      end
      pending_reads <= expected_bins.size();
   end

endmodule

// ===== verif/alternating_triggered_window_averager_tb.sv =====
`timescale 1ns / 100ps
// Top of the averager testbench: clock, reset, stimulus, register phases and
// the verdict. Depends on atwa_pkg, the averager RTL and atwa_bin_checker.

module alternating_triggered_window_averager_tb;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   // one push may be sweeping with two more queued behind it: three sweeps
   localparam int SETTLE_CYCLES        = 4000;
   localparam int FIRST_PHASE_BEATS    = 1100;
   localparam int LATER_PHASE_BEATS    = 60;
   localparam int ALPHA_PHASES         = 5;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   atwa_pkg::atwa_req_type       req_data    = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   atwa_pkg::atwa_rsp_type       rsp_data;
   logic                         csr_wr_en   = 1'b0;
   logic [atwa_pkg::ALPHA_W-1:0] csr_wr_data = '0;

   int                           mismatch_count;
   int                           pending_reads;
   int                           calm_beats  = 0;
   logic [atwa_pkg::ALPHA_W-1:0] alpha_plan [ALPHA_PHASES];

   alternating_triggered_window_averager i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   atwa_bin_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_reads  (pending_reads)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short idle spans, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic atwa_pkg::atwa_req_type make_req(logic [1:0] cmd,
                                                       logic signed [15:0] smp,
                                                       logic mark, logic sel,
                                                       logic [9:0] idx);
      atwa_pkg::atwa_req_type rq;
      rq.command      = cmd;
      rq.sample_value = smp;
      rq.event_mark   = mark;
      rq.read_select  = sel;
      rq.read_index   = idx;
      return rq;
   endfunction

   // Random beat; unused fields carry random bits as well
   function automatic atwa_pkg::atwa_req_type random_req(int push_pct, int read_pct,
                                                         bit clear_ok);
      atwa_pkg::atwa_req_type rq;
      int           r;
      int           s;
      rq.sample_value = 16'($urandom);
      s = $urandom_range(0, 15);
      if (s == 0)
         rq.sample_value = 16'sh7fff;
      else if (s == 1)
         rq.sample_value = 16'sh8000;
      rq.event_mark  = ($urandom_range(0, 7) == 0);
      rq.read_select = 1'($urandom);
      rq.read_index  = 10'($urandom);
      r = $urandom_range(0, 99);
      if (r < push_pct)
         rq.command = atwa_pkg::CMD_PUSH;
      else if (r < push_pct + read_pct)
         rq.command = atwa_pkg::CMD_READ;
      else if (clear_ok && r == 99)
         rq.command = atwa_pkg::CMD_CLEAR;
      else if (r >= 97)
         rq.command = CMD_UNUSED;
      else
         rq.command = atwa_pkg::CMD_PUSH;
      return rq;
   endfunction

   // Offer one request beat and hold it until taken
   task automatic send_beat(input atwa_pkg::atwa_req_type rq);
      int gap;
      if (calm_beats > 0) begin
         calm_beats--;
         gap = 0;
      end else begin
         gap = idle_span();
         if ($urandom_range(0, 39) == 0)
            calm_beats = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop sending, let every read answer arrive, then cover pending sweeps
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      wait (pending_reads == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Response side back-pressure, with quiet stretches
   initial begin
      forever begin
         if ($urandom_range(0, 19) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(60, 200)) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
            repeat (idle_span() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      alpha_plan[0] = '0;
      alpha_plan[1] = atwa_pkg::ALPHA_ONE;
      alpha_plan[2] = '1;
      alpha_plan[3] = 17'd1;
      alpha_plan[4] = 17'($urandom_range(1, atwa_pkg::ALPHA_ONE - 1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reads before any window, unused code, early marks, clear
      send_beat(make_req(atwa_pkg::CMD_READ,  16'sh0000, 1'b0, 1'b0, 10'd0));
      send_beat(make_req(atwa_pkg::CMD_READ,  16'sh7fff, 1'b1, 1'b1, 10'd1023));
      send_beat(make_req(CMD_UNUSED,          16'shffff, 1'b1, 1'b1, 10'd1023));
      send_beat(make_req(atwa_pkg::CMD_PUSH,  16'sh7fff, 1'b1, 1'b0, 10'd0));
      send_beat(make_req(atwa_pkg::CMD_PUSH,  16'sh8000, 1'b1, 1'b1, 10'd1023));
      send_beat(make_req(atwa_pkg::CMD_PUSH,  16'sh0000, 1'b0, 1'b0, 10'd0));
      send_beat(make_req(atwa_pkg::CMD_READ,  16'sh8000, 1'b1, 1'b0, 10'd1023));
      send_beat(make_req(atwa_pkg::CMD_CLEAR, 16'sh8000, 1'b1, 1'b1, 10'd1023));
      send_beat(make_req(atwa_pkg::CMD_READ,  16'sh7fff, 1'b0, 1'b1, 10'd0));
      send_beat(make_req(atwa_pkg::CMD_PUSH,  16'shffff, 1'b1, 1'b0, 10'h155));
      send_beat(make_req(atwa_pkg::CMD_PUSH,  16'sh0001, 1'b0, 1'b1, 10'h2aa));
      send_beat(make_req(atwa_pkg::CMD_READ,  16'sh0000, 1'b0, 1'b1, 10'd512));

      // Random: a long first phase fills the history, later phases vary alpha
      for (int p = 0; p <= ALPHA_PHASES; p++) begin
         if (p > 0) begin
            drain_and_settle();
            csr_wr_en   <= 1'b1;
            csr_wr_data <= alpha_plan[p-1];
            @(negedge clock);
            csr_wr_en   <= 1'b0;
         end
         for (int n = 0; n < ((p == 0) ? FIRST_PHASE_BEATS : LATER_PHASE_BEATS); n++) begin
            if (p == 0)
               send_beat(random_req(95, 3, n < 200));
            else
               send_beat(random_req(75, 22, 1'b0));
         end
      end

      drain_and_settle();
      if (mismatch_count == 0 && pending_reads == 0)
         $display("alternating_triggered_window_averager: match");
      else
         $display("alternating_triggered_window_averager: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("alternating_triggered_window_averager: mismatch");
      $finish;
   end

endmodule
